### hdl/hll_pkg.sv
// shared types, constants and helpers for the hid led layout parser
package hll_pkg;

    // usage list geometry
    localparam int USAGE_SLOTS = 32;
    localparam int FILL_W      = $clog2(USAGE_SLOTS + 1);
    localparam int IDX_W       = $clog2(USAGE_SLOTS);

    // width of the shared arithmetic unit (16-bit usage plus carry)
    localparam int ALU_W = 17;

    // item types
    localparam logic [1:0] ITEM_MAIN   = 2'd0;
    localparam logic [1:0] ITEM_GLOBAL = 2'd1;
    localparam logic [1:0] ITEM_LOCAL  = 2'd2;

    // global tags
    localparam logic [3:0] TAG_USAGE_PAGE = 4'h0;
    localparam logic [3:0] TAG_REPORT_ID  = 4'h8;

    // local tags
    localparam logic [3:0] TAG_USAGE     = 4'h0;
    localparam logic [3:0] TAG_USAGE_MIN = 4'h1;
    localparam logic [3:0] TAG_USAGE_MAX = 4'h2;

    // main tags
    localparam logic [3:0] TAG_OUTPUT = 4'h9;

    // led page and led usages
    localparam logic [15:0] LED_PAGE     = 16'h0008;
    localparam logic [15:0] USAGE_NUM    = 16'h0001;
    localparam logic [15:0] USAGE_CAPS   = 16'h0002;
    localparam logic [15:0] USAGE_SCROLL = 16'h0003;

    // size code that stands for four data bytes
    localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

    // input request
    typedef struct packed {
        logic [7:0] desc_byte;
        logic       last_byte;
    } desc_t;

    // output request
    typedef struct packed {
        logic       uses_report_id;
        logic [7:0] led_report_id;
        logic [7:0] num_lock_position;
        logic [7:0] caps_lock_position;
        logic [7:0] scroll_lock_position;
        logic       num_lock_present;
        logic       caps_lock_present;
        logic       scroll_lock_present;
        logic       layout_found;
    } layout_t;

    // item handed from the byte assembler to the executor
    typedef struct packed {
        logic        run;
        logic        last;
        logic [7:0]  prefix;
        logic [31:0] value;
    } cmd_t;

    // executor sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RANGE,
        ST_SCAN,
        ST_ADVANCE,
        ST_FINISH
    } exec_state_t;

    // number of data bytes that follow a prefix
    function automatic logic [2:0] item_size(input logic [7:0] prefix);
        logic [2:0] size;
        if (prefix[1:0] == SIZE_CODE_FOUR)
        begin
            size = 3'd4;
        end
        else
        begin
            size = {1'b0, prefix[1:0]};
        end
        return size;
    endfunction

endpackage

### hdl/hll_byte_asm.sv
// splits descriptor bytes into short items and assembles their data
module hll_byte_asm
    import hll_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  desc_t desc,
    output cmd_t  cmd
);

    logic [2:0]  left_reg,   left_next;
    logic [7:0]  prefix_reg, prefix_next;
    logic [31:0] value_reg,  value_next;
    logic [2:0]  size_cur;
    logic [1:0]  byte_idx;
    logic        run;

    // next item state for the incoming byte
    always_comb
    begin
        size_cur = item_size(prefix_reg);
        byte_idx = 2'(size_cur - left_reg);
        if (left_reg == 3'd0)
        begin
            prefix_next = desc.desc_byte;
            value_next  = 32'd0;
            left_next   = item_size(desc.desc_byte);
            run         = (item_size(desc.desc_byte) == 3'd0);
        end
        else
        begin
            prefix_next = prefix_reg;
            value_next  = value_reg | (32'(desc.desc_byte) << {byte_idx, 3'b000});
            left_next   = left_reg - 3'd1;
            run         = (left_reg == 3'd1);
        end
    end

    // completed item, valid when accept is high
    always_comb
    begin
        cmd.run    = run;
        cmd.last   = desc.last_byte;
        cmd.prefix = prefix_next;
        cmd.value  = value_next;
    end

    // item state, back to prefix expected after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= 3'd0;
            prefix_reg <= 8'd0;
            value_reg  <= 32'd0;
        end
        else if (accept)
        begin
            if (desc.last_byte)
            begin
                left_reg   <= 3'd0;
                prefix_reg <= 8'd0;
                value_reg  <= 32'd0;
            end
            else
            begin
                left_reg   <= left_next;
                prefix_reg <= prefix_next;
                value_reg  <= value_next;
            end
        end
    end

endmodule

### hdl/hll_exec.sv
// item executor: parser state, usage memory and the sequencer around one shared unit
module hll_exec
    import hll_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    input  logic    out_free,
    output logic    idle,
    output logic    emit,
    output layout_t layout
);

    exec_state_t state_reg, state_next;

    cmd_t              cmd_reg;
    logic [15:0]       page_reg,  page_next;
    logic [7:0]        rid_reg,   rid_next;
    logic [FILL_W-1:0] fill_reg,  fill_next;
    logic [15:0]       low_reg,   low_next;
    logic [7:0]        base_reg,  base_next;
    logic [ALU_W-1:0]  cur_reg,   cur_next;
    logic [15:0]       hi_reg,    hi_next;
    logic [FILL_W-1:0] idx_reg,   idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [7:0]        chk_pos_reg, chk_pos_next;
    layout_t           layout_reg, layout_next;

    // usage memory
    logic [15:0]       usage_mem [USAGE_SLOTS];
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [15:0]       rd_data_reg;

    // shared arithmetic and compare unit
    logic [ALU_W-1:0]  alu_a, alu_b;
    logic [ALU_W-1:0]  alu_inc, alu_sum;
    logic              alu_lt, alu_le;

    logic [1:0]        item_type;
    logic [3:0]        item_tag;
    logic              full;

    assign alu_inc = alu_a + ALU_W'(1);
    assign alu_sum = alu_a + alu_b;
    assign alu_lt  = (alu_a < alu_b);
    assign alu_le  = alu_lt || (alu_a == alu_b);

    assign item_type = cmd_reg.prefix[3:2];
    assign item_tag  = cmd_reg.prefix[7:4];
    assign full      = (fill_reg == FILL_W'(USAGE_SLOTS));

    assign idle   = (state_reg == ST_IDLE);
    assign layout = layout_reg;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        page_next    = page_reg;
        rid_next     = rid_reg;
        fill_next    = fill_reg;
        low_next     = low_reg;
        base_next    = base_reg;
        cur_next     = cur_reg;
        hi_next      = hi_reg;
        idx_next     = idx_reg;
        chk_vld_next = 1'b0;
        chk_pos_next = chk_pos_reg;
        layout_next  = layout_reg;
        wr_en        = 1'b0;
        wr_addr      = fill_reg[IDX_W-1:0];
        wr_data      = cmd_reg.value[15:0];
        rd_en        = 1'b0;
        rd_addr      = idx_reg[IDX_W-1:0];
        alu_a        = ALU_W'(fill_reg);
        alu_b        = ALU_W'(USAGE_SLOTS);
        emit         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_FINISH;
                if (cmd_reg.run)
                begin
                    case (item_type)
                        ITEM_GLOBAL:
                        begin
                            if (item_tag == TAG_USAGE_PAGE)
                            begin
                                page_next = cmd_reg.value[15:0];
                            end
                            else if (item_tag == TAG_REPORT_ID)
                            begin
                                rid_next = cmd_reg.value[7:0];
                            end
                        end

                        ITEM_LOCAL:
                        begin
                            if (item_tag == TAG_USAGE)
                            begin
                                // single usage, dropped once the list is full
                                if (alu_lt)
                                begin
                                    wr_en     = 1'b1;
                                    fill_next = alu_inc[FILL_W-1:0];
                                end
                            end
                            else if (item_tag == TAG_USAGE_MIN)
                            begin
                                low_next = cmd_reg.value[15:0];
                            end
                            else if (item_tag == TAG_USAGE_MAX)
                            begin
                                cur_next   = ALU_W'(low_reg);
                                hi_next    = cmd_reg.value[15:0];
                                state_next = ST_RANGE;
                            end
                        end

                        ITEM_MAIN:
                        begin
                            if (item_tag == TAG_OUTPUT)
                            begin
                                if (page_reg == LED_PAGE)
                                begin
                                    layout_next.uses_report_id = (rid_reg != 8'd0);
                                    layout_next.led_report_id  = rid_reg;
                                    layout_next.layout_found   = 1'b1;
                                    idx_next                   = '0;
                                    state_next                 = ST_SCAN;
                                end
                                else
                                begin
                                    state_next = ST_ADVANCE;
                                end
                            end
                            else
                            begin
                                fill_next = '0;
                                low_next  = 16'd0;
                            end
                        end

                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            // one usage of the min..max range stored per cycle
            ST_RANGE:
            begin
                alu_a   = cur_reg;
                alu_b   = ALU_W'(hi_reg);
                wr_data = cur_reg[15:0];
                if (alu_le && !full)
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + FILL_W'(1);
                    cur_next  = alu_inc;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            // read one entry per cycle, check it in the next cycle
            ST_SCAN:
            begin
                alu_a = ALU_W'(idx_reg);
                alu_b = ALU_W'(fill_reg);
                if (alu_lt)
                begin
                    rd_en        = 1'b1;
                    idx_next     = alu_inc[FILL_W-1:0];
                    chk_vld_next = 1'b1;
                    chk_pos_next = base_reg + 8'(idx_reg);
                end
                else if (!chk_vld_reg)
                begin
                    state_next = ST_ADVANCE;
                end
                if (chk_vld_reg)
                begin
                    if (rd_data_reg == USAGE_NUM)
                    begin
                        layout_next.num_lock_position = chk_pos_reg;
                        layout_next.num_lock_present  = 1'b1;
                    end
                    else if (rd_data_reg == USAGE_CAPS)
                    begin
                        layout_next.caps_lock_position = chk_pos_reg;
                        layout_next.caps_lock_present  = 1'b1;
                    end
                    else if (rd_data_reg == USAGE_SCROLL)
                    begin
                        layout_next.scroll_lock_position = chk_pos_reg;
                        layout_next.scroll_lock_present  = 1'b1;
                    end
                end
            end

            // output item: bit base moves past its usages, locals cleared
            ST_ADVANCE:
            begin
                alu_a      = ALU_W'(base_reg);
                alu_b      = ALU_W'(fill_reg);
                base_next  = alu_sum[7:0];
                fill_next  = '0;
                low_next   = 16'd0;
                state_next = ST_FINISH;
            end

            // layout emitted and parse restarted on a last byte, else back to idle
            ST_FINISH:
            begin
                if (!cmd_reg.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    page_next  = 16'd0;
                    rid_next   = 8'd0;
                    fill_next  = '0;
                    low_next   = 16'd0;
                    base_next  = 8'd0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // parser state and layout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg    <= 16'd0;
            rid_reg     <= 8'd0;
            fill_reg    <= '0;
            low_reg     <= 16'd0;
            base_reg    <= 8'd0;
            idx_reg     <= '0;
            chk_vld_reg <= 1'b0;
            layout_reg  <= '{
                uses_report_id:       1'b0,
                led_report_id:        8'd0,
                num_lock_position:    8'd0,
                caps_lock_position:   8'd1,
                scroll_lock_position: 8'd2,
                num_lock_present:     1'b1,
                caps_lock_present:    1'b1,
                scroll_lock_present:  1'b1,
                layout_found:         1'b0
            };
        end
        else
        begin
            page_reg    <= page_next;
            rid_reg     <= rid_next;
            fill_reg    <= fill_next;
            low_reg     <= low_next;
            base_reg    <= base_next;
            idx_reg     <= idx_next;
            chk_vld_reg <= chk_vld_next;
            layout_reg  <= layout_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && idle)
        begin
            cmd_reg <= cmd;
        end
        cur_reg     <= cur_next;
        hi_reg      <= hi_next;
        chk_pos_reg <= chk_pos_next;
    end

    // usage memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            usage_mem[wr_addr] <= wr_data;
        end
    end

    // usage memory read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= usage_mem[rd_addr];
        end
    end

    // fill count never passes the list size
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(USAGE_SLOTS))
        else $error("usage fill count overflow");

    // layout leaves only from the finish step of a last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (state_reg == ST_FINISH) && cmd_reg.last)
        else $error("layout emitted outside end of descriptor");

    // a pending check only follows a scan read
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> $past(rd_en) && (state_reg == ST_SCAN))
        else $error("scan check without a memory read");

    // a new item is only taken while idle, and work follows it
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && idle) |=> (state_reg == ST_EXEC))
        else $error("accepted item not executed");

    // memory writes happen only while storing usages
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full && ((state_reg == ST_EXEC) || (state_reg == ST_RANGE)))
        else $error("usage write outside usage storing");

endmodule

### hdl/hid_led_layout_descriptor_parser_top.sv
// top level of the hid led layout parser with its output register
//
// Takes a HID report descriptor one byte per request and, on the request
// that carries last_byte, returns one layout request with the report id and
// bit positions of the Num, Caps and Scroll Lock LEDs; the layout persists
// across descriptors. Each byte passes through a small sequencer around one
// shared adder and comparator. A usage maximum item stores the range one
// usage at a time and then closes it. An Output main item moves the bit
// base past its usages, and on the LED page first scans the usage list
// through the registered read port of the usage memory.
// desc_ready is low while a byte is being worked on; the last byte of a
// descriptor also waits until the output register is free.
module hid_led_layout_descriptor_parser_top
    import hll_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    desc_valid,
    output logic    desc_ready,
    input  desc_t   desc,
    output logic    layout_valid,
    input  logic    layout_ready,
    output layout_t layout
);

    logic    accept;
    cmd_t    cmd;
    logic    idle;
    logic    emit;
    logic    out_free;
    layout_t layout_now;
    logic    out_valid_reg;
    layout_t out_reg;

    assign desc_ready   = idle;
    assign accept       = desc_valid && desc_ready;
    assign out_free     = !out_valid_reg || layout_ready;
    assign layout_valid = out_valid_reg;
    assign layout       = out_reg;

    // byte to item assembly
    hll_byte_asm u_byte_asm (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .desc   (desc),
        .cmd    (cmd)
    );

    // item execution
    hll_exec u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .cmd      (cmd),
        .out_free (out_free),
        .idle     (idle),
        .emit     (emit),
        .layout   (layout_now)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (layout_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= layout_now;
        end
    end

endmodule

### dv/hid_led_layout_descriptor_parser_top_tb.sv
// testbench for the hid led layout descriptor parser top level
`timescale 1ns / 1ps

module hid_led_layout_descriptor_parser_top_tb;
    import hll_pkg::*;

    // codes the block ignores or treats as plain main items
    localparam logic [1:0] ITEM_RESERVED      = 2'd3;
    localparam logic [3:0] TAG_INPUT          = 4'h8;
    localparam logic [3:0] TAG_COLLECTION     = 4'hA;
    localparam logic [3:0] TAG_END_COLLECTION = 4'hC;
    localparam logic [7:0] LONG_PREFIX        = 8'hFE;

    localparam int MIN_BYTES     = 500;
    localparam int MIN_DESCS     = 16;
    localparam int DRAIN_CYCLES  = 80;
    localparam int STALL_LIMIT   = 4000;

    logic    clk;
    logic    rst_n;
    logic    desc_valid;
    logic    desc_ready;
    desc_t   desc;
    logic    layout_valid;
    logic    layout_ready;
    layout_t layout;

    hid_led_layout_descriptor_parser_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc_valid   (desc_valid),
        .desc_ready   (desc_ready),
        .desc         (desc),
        .layout_valid (layout_valid),
        .layout_ready (layout_ready),
        .layout       (layout)
    );

    // descriptor bytes waiting to be sent and layouts waiting to come back
    desc_t   byte_queue[$];
    layout_t expected_layouts[$];
    layout_t oldest_layout;

    int total_bytes;
    int issued_bytes;
    int accepted_bytes;
    int descriptor_count;
    int layouts_compared;
    int leds_found;
    int mismatches;
    int stall_cycles;

    // parser state mirrored from the descriptor stream
    logic [2:0]  p_left;
    logic [7:0]  p_prefix;
    logic [31:0] p_value;
    logic [15:0] p_page;
    logic [7:0]  p_rid;
    logic [15:0] p_usages [USAGE_SLOTS];
    int          p_fill;
    logic [15:0] p_min;
    logic [7:0]  p_base;
    layout_t     p_layout;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    task automatic compare_layout(input layout_t got, input layout_t want);
        check_field("uses_report_id", got.uses_report_id, want.uses_report_id);
        check_field("led_report_id", got.led_report_id, want.led_report_id);
        check_field("num_lock_position", got.num_lock_position, want.num_lock_position);
        check_field("caps_lock_position", got.caps_lock_position, want.caps_lock_position);
        check_field("scroll_lock_position", got.scroll_lock_position,
                    want.scroll_lock_position);
        check_field("num_lock_present", got.num_lock_present, want.num_lock_present);
        check_field("caps_lock_present", got.caps_lock_present, want.caps_lock_present);
        check_field("scroll_lock_present", got.scroll_lock_present,
                    want.scroll_lock_present);
        check_field("layout_found", got.layout_found, want.layout_found);
    endtask

    // data bytes behind a prefix, size code three meaning four
    function automatic int data_len(input logic [7:0] prefix);
        return (prefix[1:0] == SIZE_CODE_FOUR) ? 4 : int'(prefix[1:0]);
    endfunction

    function automatic void restart_descriptor();
        p_left   = 3'd0;
        p_prefix = 8'd0;
        p_value  = 32'd0;
        p_page   = 16'd0;
        p_rid    = 8'd0;
        p_base   = 8'd0;
        p_fill   = 0;
        p_min    = 16'd0;
    endfunction

    function automatic void push_usage(input logic [15:0] u);
        if (p_fill < USAGE_SLOTS)
        begin
            p_usages[p_fill] = u;
            p_fill++;
        end
    endfunction

    // act on one complete short item
    function automatic void run_short_item();
        logic [1:0]  kind;
        logic [3:0]  tag;
        logic [15:0] hi;
        logic [7:0]  bitpos;
        int          k;
        kind = p_prefix[3:2];
        tag  = p_prefix[7:4];
        if (kind == ITEM_GLOBAL)
        begin
            if (tag == TAG_USAGE_PAGE)
                p_page = p_value[15:0];
            else if (tag == TAG_REPORT_ID)
                p_rid = p_value[7:0];
        end
        else if (kind == ITEM_LOCAL)
        begin
            if (tag == TAG_USAGE)
                push_usage(p_value[15:0]);
            else if (tag == TAG_USAGE_MIN)
                p_min = p_value[15:0];
            else if (tag == TAG_USAGE_MAX)
            begin
                hi = p_value[15:0];
                // inclusive range, cut short once the list is full
                if (hi >= p_min)
                begin
                    for (k = p_min; k <= hi && p_fill < USAGE_SLOTS; k++)
                        push_usage(k[15:0]);
                end
            end
        end
        else if (kind == ITEM_MAIN)
        begin
            if (tag == TAG_OUTPUT)
            begin
                if (p_page == LED_PAGE)
                begin
                    p_layout.uses_report_id = (p_rid != 8'd0);
                    p_layout.led_report_id  = p_rid;
                    p_layout.layout_found   = 1'b1;
                    for (k = 0; k < p_fill; k++)
                    begin
                        bitpos = p_base + k[7:0];
                        if (p_usages[k] == USAGE_NUM)
                        begin
                            p_layout.num_lock_position = bitpos;
                            p_layout.num_lock_present  = 1'b1;
                        end
                        else if (p_usages[k] == USAGE_CAPS)
                        begin
                            p_layout.caps_lock_position = bitpos;
                            p_layout.caps_lock_present  = 1'b1;
                        end
                        else if (p_usages[k] == USAGE_SCROLL)
                        begin
                            p_layout.scroll_lock_position = bitpos;
                            p_layout.scroll_lock_present  = 1'b1;
                        end
                    end
                end
                // bit base advances on every output item, wrapping at 256
                p_base = p_base + p_fill[7:0];
            end
            p_fill = 0;
            p_min  = 16'd0;
        end
    endfunction

    // assemble one accepted byte and predict the layout on the last one
    function automatic void parse_desc_byte(input desc_t d);
        logic [2:0] idx;
        if (p_left == 3'd0)
        begin
            p_prefix = d.desc_byte;
            p_value  = 32'd0;
            p_left   = 3'(data_len(d.desc_byte));
            if (p_left == 3'd0)
                run_short_item();
        end
        else
        begin
            idx     = 3'(data_len(p_prefix)) - p_left;
            p_value = p_value | ({24'd0, d.desc_byte} << (8 * idx[1:0]));
            p_left  = p_left - 3'd1;
            if (p_left == 3'd0)
                run_short_item();
        end
        // a short final item is dropped by the restart
        if (d.last_byte)
        begin
            restart_descriptor();
            expected_layouts.push_back(p_layout);
        end
    endfunction

    // stimulus building
    task automatic push_byte(input logic [7:0] b);
        desc_t d;
        d.desc_byte = b;
        d.last_byte = 1'b0;
        byte_queue.push_back(d);
    endtask

    task automatic add_sized(input logic [1:0] kind, input logic [3:0] tag,
                             input logic [31:0] value, input int len);
        logic [1:0] code;
        int         i;
        code = (len == 4) ? SIZE_CODE_FOUR : 2'(len);
        push_byte({tag, kind, code});
        for (i = 0; i < len; i++)
            push_byte(value[8 * i +: 8]);
    endtask

    // smallest size that holds the value, sometimes widened
    task automatic add_item(input logic [1:0] kind, input logic [3:0] tag,
                            input logic [31:0] value);
        int len;
        if (value == 32'd0)
            len = 0;
        else if (value < 32'd256)
            len = 1;
        else if (value < 32'd65536)
            len = 2;
        else
            len = 4;
        if (len < 4 && $urandom_range(0, 3) == 0)
            len = (len == 2) ? 4 : len + 1;
        add_sized(kind, tag, value, len);
    endtask

    task automatic end_descriptor();
        byte_queue[byte_queue.size() - 1].last_byte = 1'b1;
        descriptor_count++;
    endtask

    // idling phases by progress: none, sender, receiver, both
    function automatic int idle_phase();
        int ph;
        ph = (accepted_bytes * 4) / total_bytes;
        return (ph > 3) ? 3 : ph;
    endfunction

    function automatic bit sender_holds();
        int ph;
        ph = idle_phase();
        if (ph == 1)
            return $urandom_range(0, 99) < 81;
        if (ph == 3)
            return $urandom_range(0, 99) < 21;
        return 1'b0;
    endfunction

    function automatic bit receiver_holds();
        int ph;
        ph = idle_phase();
        if (ph == 2)
            return $urandom_range(0, 99) < 81;
        if (ph == 3)
            return $urandom_range(0, 99) < 21;
        return 1'b0;
    endfunction

    // request driver, falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!desc_valid || accepted_bytes == issued_bytes)
            begin
                if (byte_queue.size() > 0 && !sender_holds())
                begin
                    desc       <= byte_queue.pop_front();
                    desc_valid <= 1'b1;
                    issued_bytes++;
                end
                else
                begin
                    desc_valid <= 1'b0;
                end
            end
            layout_ready <= !receiver_holds();
        end
    end

    // monitor and checker, rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (desc_valid && desc_ready)
            begin
                parse_desc_byte(desc);
                accepted_bytes++;
            end
            if (layout_valid && layout_ready)
            begin
                if (expected_layouts.size() == 0)
                begin
                    report_mismatch("layout request with no descriptor end pending");
                end
                else
                begin
                    oldest_layout = expected_layouts.pop_front();
                    compare_layout(layout, oldest_layout);
                    layouts_compared++;
                    if (oldest_layout.layout_found)
                        leds_found++;
                end
            end
            if ((desc_valid && desc_ready) || (layout_valid && layout_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // watchdog on cycles with no request moving
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int         n_items;
        int         i;
        int         j;
        int         r;
        int         len;
        logic [7:0] pfx;
        logic [3:0] tag;
        logic [31:0] v;

        clk          = 1'b0;
        rst_n        = 1'b0;
        desc_valid   = 1'b0;
        desc         = '0;
        layout_ready = 1'b0;
        stall_cycles = 0;

        restart_descriptor();
        p_layout                      = '0;
        p_layout.caps_lock_position   = 8'd1;
        p_layout.scroll_lock_position = 8'd2;
        p_layout.num_lock_present     = 1'b1;
        p_layout.caps_lock_present    = 1'b1;
        p_layout.scroll_lock_present  = 1'b1;

        // lone main item: the reset layout comes back
        add_sized(ITEM_MAIN, TAG_END_COLLECTION, 32'd0, 0);
        end_descriptor();

        // led output with wide values truncated, then a short final item
        add_sized(ITEM_GLOBAL, TAG_USAGE_PAGE, 32'hFFFF_0008, 4);
        add_sized(ITEM_GLOBAL, TAG_REPORT_ID, 32'h0000_01FF, 2);
        add_sized(ITEM_LOCAL, TAG_USAGE, 32'(USAGE_SCROLL), 1);
        add_sized(ITEM_LOCAL, TAG_USAGE, 32'hABCD_0002, 4);
        add_sized(ITEM_MAIN, TAG_OUTPUT, 32'h0000_0002, 1);
        push_byte({TAG_REPORT_ID, ITEM_GLOBAL, 2'd2});
        push_byte(8'h5A);
        end_descriptor();

        // long prefix, reserved type, empty range, off-page output
        push_byte(LONG_PREFIX);
        push_byte(8'(($urandom())));
        push_byte(8'(($urandom())));
        add_sized(ITEM_RESERVED, 4'($urandom()), 32'd0, 0);
        add_sized(ITEM_LOCAL, TAG_USAGE_MIN, 32'd5, 1);
        add_sized(ITEM_LOCAL, TAG_USAGE_MAX, 32'd2, 1);
        add_sized(ITEM_MAIN, TAG_OUTPUT, 32'd0, 0);
        end_descriptor();

        // random descriptors, mostly well formed
        while (byte_queue.size() < MIN_BYTES || descriptor_count < MIN_DESCS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // pure byte noise
                len = $urandom_range(1, 12);
                for (i = 0; i < len; i++)
                    push_byte(8'($urandom()));
            end
            else
            begin
                n_items = $urandom_range(3, 14);
                for (i = 0; i < n_items; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 12)
                    begin
                        v = ($urandom_range(0, 9) < 7) ? 32'(LED_PAGE) : $urandom_range(0, 12);
                        if ($urandom_range(0, 9) == 0)
                            v = $urandom();
                        add_item(ITEM_GLOBAL, TAG_USAGE_PAGE, v);
                    end
                    else if (r < 20)
                    begin
                        v = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom_range(1, 255);
                        if ($urandom_range(0, 9) == 0)
                            v = $urandom();
                        add_item(ITEM_GLOBAL, TAG_REPORT_ID, v);
                    end
                    else if (r < 38)
                    begin
                        v = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 5);
                        add_item(ITEM_LOCAL, TAG_USAGE, v);
                    end
                    else if (r < 48)
                    begin
                        v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 5);
                        add_item(ITEM_LOCAL, TAG_USAGE_MIN, v);
                    end
                    else if (r < 60)
                    begin
                        v = $urandom_range(0, 40);
                        if ($urandom_range(0, 9) == 0)
                            v = ($urandom_range(0, 1) == 0) ? 32'h0000_FFFF : $urandom();
                        add_item(ITEM_LOCAL, TAG_USAGE_MAX, v);
                    end
                    else if (r < 75)
                    begin
                        add_item(ITEM_MAIN, TAG_OUTPUT, $urandom_range(0, 255));
                    end
                    else if (r < 82)
                    begin
                        j = $urandom_range(0, 3);
                        tag = (j == 0) ? TAG_INPUT : (j == 1) ? TAG_COLLECTION :
                              (j == 2) ? TAG_END_COLLECTION : 4'($urandom());
                        add_item(ITEM_MAIN, tag, $urandom_range(0, 255));
                    end
                    else if (r < 88)
                    begin
                        // full list of padding bits pushes the base toward wrap
                        add_item(ITEM_LOCAL, TAG_USAGE_MIN, 32'd0);
                        add_item(ITEM_LOCAL, TAG_USAGE_MAX, 32'(USAGE_SLOTS - 1));
                        add_item(ITEM_MAIN, TAG_OUTPUT, 32'd0);
                    end
                    else if (r < 94)
                    begin
                        pfx = 8'($urandom());
                        push_byte(pfx);
                        for (j = 0; j < data_len(pfx); j++)
                            push_byte(8'($urandom()));
                    end
                    else if ($urandom_range(0, 1) == 0)
                    begin
                        push_byte(LONG_PREFIX);
                        push_byte(8'($urandom()));
                        push_byte(8'($urandom()));
                    end
                    else
                    begin
                        add_item(ITEM_RESERVED, 4'($urandom()), $urandom());
                    end
                end
                // sometimes cut the final item short
                if ($urandom_range(0, 99) < 15)
                begin
                    pfx = {6'($urandom()), 2'($urandom_range(1, 3))};
                    push_byte(pfx);
                    len = $urandom_range(0, data_len(pfx) - 1);
                    for (j = 0; j < len; j++)
                        push_byte(8'($urandom()));
                end
            end
            end_descriptor();
        end
        total_bytes = byte_queue.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_queue.size() != 0 || accepted_bytes != issued_bytes ||
               expected_layouts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d descriptor bytes in %0d descriptors over four idling phases",
                 accepted_bytes, descriptor_count);
        $display("compared %0d layouts, %0d of them after an led output item, %0d mismatches",
                 layouts_compared, leds_found, mismatches);
        if (mismatches == 0 && expected_layouts.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
